/* design/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants for the S-expression boundary checker.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TICK   = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h00;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2,
        ST_END      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LEAD_CLOSE = 3'd1,
        ERR_EXTRA      = 3'd2,
        ERR_TRAILING   = 3'd3,
        ERR_STR_ATOM   = 3'd4,
        ERR_OPEN_STR   = 3'd5,
        ERR_MISSING    = 3'd6,
        ERR_TOO_DEEP   = 3'd7
    } err_t;

    typedef enum logic [2:0] {
        KIND_NOTHING  = 3'd0,
        KIND_STRING   = 3'd1,
        KIND_ATOM     = 3'd2,
        KIND_LIST     = 3'd3,
        KIND_FINISHED = 3'd4
    } kind_t;

    // Byte class decoded by the front part; the back part sees only these flags.
    typedef struct packed {
        logic eoi;
        logic nl;
        logic blank;
        logic semi_zero;
        logic open;
        logic close;
        logic quote;
        logic hash;
        logic bslash;
        logic tick;
    } byte_class_t;

endpackage

/* design/sbc_front.sv */
// ----------------------------------------------------------------------------
// sbc_front
// Accepts input beats, classifies each byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module sbc_front
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        end_of_input,
    output logic        cls_valid,
    output byte_class_t cls_data,
    input  logic        cls_take
);

    byte_class_t cls_in;
    byte_class_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        wr_en;
    logic        rd_en;

    always_comb
    begin
        cls_in.eoi       = end_of_input;
        cls_in.nl        = (text_byte == CH_NL);
        cls_in.blank     = (text_byte == CH_SPACE) ||
                           (text_byte >= 8'h09 && text_byte <= 8'h0D);
        cls_in.semi_zero = (text_byte == CH_SEMI) || (text_byte == CH_ZERO);
        cls_in.open      = (text_byte == CH_OPEN);
        cls_in.close     = (text_byte == CH_CLOSE);
        cls_in.quote     = (text_byte == CH_QUOTE);
        cls_in.hash      = (text_byte == CH_HASH);
        cls_in.bslash    = (text_byte == CH_BSLASH);
        cls_in.tick      = (text_byte == CH_TICK);
    end

    assign full      = (count_reg == 2'd2);
    assign cls_valid = (count_reg != 2'd0);
    assign cls_data  = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cls_take && cls_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= cls_in;
        end
    end

endmodule

/* design/sbc_back.sv */
// ----------------------------------------------------------------------------
// sbc_back
// Parser state update for one classified byte per cycle while the result queue
// has room, with a two-entry result queue toward the consumer.
// ----------------------------------------------------------------------------
module sbc_back
    import sbc_pkg::*;
#(
    parameter int MAX_NEST = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cls_valid,
    input  byte_class_t cls_data,
    output logic        cls_take,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [2:0]  error_code,
    output logic [7:0]  depth_now
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 1);

    typedef struct packed {
        status_t     st;
        err_t        code;
        logic [7:0]  depth;
    } result_t;

    // Parser state
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               instr_reg, instr_next;
    kind_t              kind_reg, kind_next;
    logic               content_reg, content_next;
    logic               skip_reg, skip_next;
    logic               prev_hash_reg, prev_hash_next;
    logic               prev_bs_reg, prev_bs_next;
    logic               prev_tick_reg, prev_tick_next;
    logic               pp_hash_reg, pp_hash_next;
    logic [1:0]         pos_reg, pos_next;

    // Result queue
    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        rd_en;

    result_t            res;
    logic               failed;
    err_t               fail_code;
    logic               escaped;
    logic [DEPTH_W-1:0] depth_dec;
    logic [DEPTH_W+7:0] depth_ext;

    assign cls_take = cls_valid && ((count_reg != 2'd2) || (pop && !empty));
    assign escaped  = (pos_reg == 2'd2) && prev_bs_reg && pp_hash_reg;
    assign depth_dec = depth_reg - DEPTH_W'(1);

    always_comb
    begin
        depth_next     = depth_reg;
        instr_next     = instr_reg;
        kind_next      = kind_reg;
        content_next   = content_reg;
        skip_next      = skip_reg;
        prev_hash_next = prev_hash_reg;
        prev_bs_next   = prev_bs_reg;
        prev_tick_next = prev_tick_reg;
        pp_hash_next   = pp_hash_reg;
        pos_next       = pos_reg;
        res.st         = ST_CONTINUE;
        res.code       = ERR_NONE;
        failed         = 1'b0;
        fail_code      = ERR_NONE;

        if (cls_data.eoi)
        begin
            if (instr_reg)
            begin
                res.st   = ST_ERROR;
                res.code = ERR_OPEN_STR;
            end
            else if (depth_reg != '0)
            begin
                res.st   = ST_ERROR;
                res.code = ERR_MISSING;
            end
            else if (content_reg)
            begin
                res.st = ST_COMPLETE;
            end
            else
            begin
                res.st = ST_END;
            end
            depth_next     = '0;
            instr_next     = 1'b0;
            kind_next      = KIND_NOTHING;
            content_next   = 1'b0;
            skip_next      = 1'b0;
            prev_hash_next = 1'b0;
            prev_bs_next   = 1'b0;
            prev_tick_next = 1'b0;
            pp_hash_next   = 1'b0;
            pos_next       = 2'd0;
        end
        else if (cls_data.nl)
        begin
            if (!skip_reg && instr_reg)
            begin
                depth_next = '0;
                instr_next = 1'b0;
                kind_next  = KIND_NOTHING;
                res.st     = ST_ERROR;
                res.code   = ERR_OPEN_STR;
            end
            else if (content_reg && depth_reg == '0)
            begin
                depth_next = '0;
                instr_next = 1'b0;
                kind_next  = KIND_NOTHING;
                res.st     = ST_COMPLETE;
            end
            content_next   = 1'b0;
            skip_next      = 1'b0;
            prev_hash_next = 1'b0;
            prev_bs_next   = 1'b0;
            prev_tick_next = 1'b0;
            pp_hash_next   = 1'b0;
            pos_next       = 2'd0;
        end
        else if (skip_reg)
        begin
            // Rest of the line is discarded.
        end
        else if (!instr_reg && cls_data.semi_zero)
        begin
            skip_next = 1'b1;
        end
        else
        begin
            if (!cls_data.blank)
            begin
                content_next = 1'b1;
            end

            if (kind_reg == KIND_FINISHED && !instr_reg)
            begin
                if (!cls_data.blank)
                begin
                    failed    = 1'b1;
                    fail_code = cls_data.close ? ERR_EXTRA : ERR_TRAILING;
                end
            end
            else if (cls_data.open)
            begin
                if (!instr_reg && !escaped)
                begin
                    if (depth_reg >= DEPTH_W'(MAX_NEST))
                    begin
                        failed    = 1'b1;
                        fail_code = ERR_TOO_DEEP;
                    end
                    else
                    begin
                        depth_next = depth_reg + DEPTH_W'(1);
                        kind_next  = KIND_LIST;
                    end
                end
            end
            else if (cls_data.close)
            begin
                if (!instr_reg && !escaped)
                begin
                    if (depth_reg == '0)
                    begin
                        failed    = 1'b1;
                        fail_code = ERR_LEAD_CLOSE;
                    end
                    else
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            kind_next = KIND_FINISHED;
                        end
                    end
                end
            end
            else if (cls_data.quote)
            begin
                // A quote right after a backslash (past the line start) is escaped.
                if (!((pos_reg == 2'd2) && prev_bs_reg))
                begin
                    if (!instr_reg)
                    begin
                        if (kind_reg == KIND_ATOM && !prev_tick_reg)
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_STR_ATOM;
                        end
                        else
                        begin
                            instr_next = 1'b1;
                            if (kind_reg != KIND_LIST)
                            begin
                                kind_next = KIND_STRING;
                            end
                        end
                    end
                    else
                    begin
                        instr_next = 1'b0;
                        if (kind_reg == KIND_STRING)
                        begin
                            kind_next = KIND_FINISHED;
                        end
                    end
                end
            end
            else if (!instr_reg)
            begin
                if (cls_data.blank)
                begin
                    if (kind_reg == KIND_ATOM)
                    begin
                        kind_next = KIND_FINISHED;
                    end
                end
                else if (kind_reg != KIND_LIST)
                begin
                    kind_next = KIND_ATOM;
                end
            end

            if (failed)
            begin
                depth_next   = '0;
                instr_next   = 1'b0;
                kind_next    = KIND_NOTHING;
                content_next = 1'b0;
                skip_next    = 1'b1;
                res.st       = ST_ERROR;
                res.code     = fail_code;
            end
            else
            begin
                pp_hash_next   = prev_hash_reg;
                prev_hash_next = cls_data.hash;
                prev_bs_next   = cls_data.bslash;
                prev_tick_next = cls_data.tick;
                if (pos_reg != 2'd2)
                begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        end

        depth_ext = {8'd0, depth_next};
        res.depth = depth_ext[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            instr_reg     <= 1'b0;
            kind_reg      <= KIND_NOTHING;
            content_reg   <= 1'b0;
            skip_reg      <= 1'b0;
            prev_hash_reg <= 1'b0;
            prev_bs_reg   <= 1'b0;
            prev_tick_reg <= 1'b0;
            pp_hash_reg   <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else if (cls_take)
        begin
            depth_reg     <= depth_next;
            instr_reg     <= instr_next;
            kind_reg      <= kind_next;
            content_reg   <= content_next;
            skip_reg      <= skip_next;
            prev_hash_reg <= prev_hash_next;
            prev_bs_reg   <= prev_bs_next;
            prev_tick_reg <= prev_tick_next;
            pp_hash_reg   <= pp_hash_next;
            pos_reg       <= pos_next;
        end
    end

    // Result queue
    assign empty      = (count_reg == 2'd0);
    assign rd_en      = pop && !empty;
    assign status     = mem_reg[rd_ptr_reg].st;
    assign error_code = mem_reg[rd_ptr_reg].code;
    assign depth_now  = mem_reg[rd_ptr_reg].depth;

    always_comb
    begin
        wr_ptr_next = cls_take ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(cls_take) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_take)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

/* design/sexpr_boundary_checker_core.sv */
// Path: a pushed byte is classified and stored in the front queue, then parsed
// by the back part when it leaves that queue; its result beat is registered in
// the result queue and shows on the result ports from there.
// Throughput: one byte per cycle while the result queue has room or is popped.
// Reset: rst_n clears both queues and all parser state (depth zero, no string,
// nothing found yet, fresh line); queued payload is not cleared.
// ----------------------------------------------------------------------------
// sexpr_boundary_checker_core
// Finds where each complete S-expression ends in a byte stream and reports,
// for every input beat, one result beat with status, error code and depth.
// ----------------------------------------------------------------------------
module sexpr_boundary_checker_core
    import sbc_pkg::*;
#(
    parameter int MAX_NEST = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    // Input side: a beat is taken when push is high and full is low.
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_input,
    // Result side: the oldest beat is shown while empty is low.
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic [2:0] error_code,
    output logic [7:0] depth_now
);

    // The front part decodes each byte into a small set of class flags, so the
    // back part never compares full bytes. The two parts are joined by a
    // two-entry queue, which lets the producer keep pushing while the back part
    // waits on a stalled consumer, and vice versa.
    byte_class_t cls_data;
    logic        cls_valid;
    logic        cls_take;

    sbc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .cls_valid    (cls_valid),
        .cls_data     (cls_data),
        .cls_take     (cls_take)
    );

    // The back part holds the parser state (depth, string flag, expression
    // kind, comment skip, and the last two byte classes of the line) and
    // writes one result beat per parsed byte into its own two-entry queue.
    // It parses a byte whenever that queue has room, including the cycle in
    // which the consumer pops a full queue.
    sbc_back #(
        .MAX_NEST (MAX_NEST)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls_valid  (cls_valid),
        .cls_data   (cls_data),
        .cls_take   (cls_take),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .error_code (error_code),
        .depth_now  (depth_now)
    );

endmodule
